### src/mm4_pkg.sv
// Shared types, widths and command/status structs of the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W = 32;
  localparam int DIM = 4;
  localparam int IDX_W = 2;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int HI_W = ACC_W - FRAC_BITS - DATA_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [DIM*DATA_W-1:0] row_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam idx_t LAST_IDX = idx_t'(DIM - 1);
  localparam data_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    idx_t row;
    idx_t kk;
    logic load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic go_accept;
    logic acc_done;
    logic out_free;
  } status_t;

endpackage

### src/mm4_channels.sv
// Valid/ready channel interfaces for the row input items and the product row items.
interface mm4_in_if;
  logic valid;
  logic ready;
  mm4_pkg::idx_t row_index;
  mm4_pkg::data_t a_col0;
  mm4_pkg::data_t a_col1;
  mm4_pkg::data_t a_col2;
  mm4_pkg::data_t a_col3;
  mm4_pkg::data_t b_col0;
  mm4_pkg::data_t b_col1;
  mm4_pkg::data_t b_col2;
  mm4_pkg::data_t b_col3;
  logic go;

  modport source (
    output valid, row_index, a_col0, a_col1, a_col2, a_col3,
    output b_col0, b_col1, b_col2, b_col3, go,
    input ready
  );
  modport sink (
    input valid, row_index, a_col0, a_col1, a_col2, a_col3,
    input b_col0, b_col1, b_col2, b_col3, go,
    output ready
  );
endinterface

interface mm4_out_if;
  logic valid;
  logic ready;
  mm4_pkg::idx_t out_row;
  mm4_pkg::data_t c_col0;
  mm4_pkg::data_t c_col1;
  mm4_pkg::data_t c_col2;
  mm4_pkg::data_t c_col3;
  logic saturated;
  logic last;

  modport source (
    output valid, out_row, c_col0, c_col1, c_col2, c_col3, saturated, last,
    input ready
  );
  modport sink (
    input valid, out_row, c_col0, c_col1, c_col2, c_col3, saturated, last,
    output ready
  );
endinterface

### src/matrix4x4_multiply_core.sv
// Top level of the 4x4 signed fixed-point matrix multiplier.
// An item without go is written into the row stores; rows is ready whenever no product is in progress.
// A go item starts a product: each row reads every term pair from the stores, passes through the
// multiply and accumulate registers and then loads the output register.
// Output stalls hold the sequencer until the output register is free.
// Synchronous reset clears the sequencer and valid flags; the row stores are not cleared.
module matrix4x4_multiply_core (
  input  logic clk,
  input  logic rst,
  mm4_in_if.sink rows,
  mm4_out_if.source product
);

  mm4_pkg::cmd_t cmd;
  mm4_pkg::status_t status;

  mm4_controller u_ctrl (
    .clk(clk),
    .rst(rst),
    .status(status),
    .cmd(cmd)
  );

  mm4_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .rows(rows),
    .product(product),
    .cmd(cmd),
    .status(status)
  );

  a_busy_after_go: assert property (@(posedge clk) disable iff (rst)
    status.go_accept |=> !rows.ready)
    else $error("Block accepted an item right after a go item.");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !rows.ready)
    else $error("Row store open for writes while the product is being read.");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    status.acc_done |-> !rows.ready)
    else $error("Accumulation finished while the sequencer was idle.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> product.valid)
    else $error("Loaded result row did not appear on the output.");

endmodule

### src/mm4_datapath.sv
// Row stores, four shared multiply-accumulate lanes, saturation and the output register.
module mm4_datapath (
  input  logic clk,
  input  logic rst,
  mm4_in_if.sink rows,
  mm4_out_if.source product,
  input  mm4_pkg::cmd_t cmd,
  output mm4_pkg::status_t status
);

  mm4_pkg::row_t left_mem [mm4_pkg::DIM];
  mm4_pkg::row_t right_mem [mm4_pkg::DIM];

  mm4_pkg::row_t a_row;
  mm4_pkg::row_t b_row;
  mm4_pkg::idx_t k1;
  logic v1;
  logic first1;
  logic last1;

  mm4_pkg::prod_t prod [mm4_pkg::DIM];
  logic v2;
  logic first2;
  logic last2;

  mm4_pkg::acc_t acc [mm4_pkg::DIM];
  logic done;

  mm4_pkg::data_t a_sel;
  mm4_pkg::data_t sat_val [mm4_pkg::DIM];
  logic [mm4_pkg::DIM-1:0] clip;

  mm4_pkg::idx_t out_row;
  mm4_pkg::data_t c_out [mm4_pkg::DIM];
  logic out_sat;
  logic out_last;
  logic out_valid;
  logic accept;

  assign rows.ready = cmd.in_ready;
  assign accept = rows.valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      left_mem[rows.row_index] <= {rows.a_col3, rows.a_col2, rows.a_col1, rows.a_col0};
      right_mem[rows.row_index] <= {rows.b_col3, rows.b_col2, rows.b_col1, rows.b_col0};
    end
    if (cmd.rd_en) begin
      a_row <= left_mem[cmd.row];
      b_row <= right_mem[cmd.kk];
      k1 <= cmd.kk;
      first1 <= (cmd.kk == '0);
      last1 <= (cmd.kk == mm4_pkg::LAST_IDX);
    end
  end

  assign a_sel = a_row[k1*mm4_pkg::DATA_W +: mm4_pkg::DATA_W];

  always_ff @(posedge clk) begin
    for (int c = 0; c < mm4_pkg::DIM; c++) begin
      if (v1) begin
        prod[c] <= $signed(a_sel) * $signed(b_row[c*mm4_pkg::DATA_W +: mm4_pkg::DATA_W]);
      end
      if (v2) begin
        if (first2) begin
          acc[c] <= mm4_pkg::ACC_W'(prod[c]);
        end else begin
          acc[c] <= acc[c] + mm4_pkg::ACC_W'(prod[c]);
        end
      end
    end
    if (v1) begin
      first2 <= first1;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      done <= v2 && last2;
    end
  end

  always_comb begin
    for (int c = 0; c < mm4_pkg::DIM; c++) begin
      logic [mm4_pkg::HI_W-1:0] hi;
      hi = acc[c][mm4_pkg::ACC_W-1:mm4_pkg::FRAC_BITS+mm4_pkg::DATA_W-1];
      clip[c] = !((&hi) || !(|hi));
      if (!clip[c]) begin
        sat_val[c] = acc[c][mm4_pkg::FRAC_BITS+mm4_pkg::DATA_W-1:mm4_pkg::FRAC_BITS];
      end else if (acc[c][mm4_pkg::ACC_W-1]) begin
        sat_val[c] = mm4_pkg::SAT_MIN;
      end else begin
        sat_val[c] = mm4_pkg::SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_row <= cmd.row;
      out_last <= cmd.out_last;
      out_sat <= |clip;
      for (int c = 0; c < mm4_pkg::DIM; c++) begin
        c_out[c] <= sat_val[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (product.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign product.valid = out_valid;
  assign product.out_row = out_row;
  assign product.c_col0 = c_out[0];
  assign product.c_col1 = c_out[1];
  assign product.c_col2 = c_out[2];
  assign product.c_col3 = c_out[3];
  assign product.saturated = out_sat;
  assign product.last = out_last;

  assign status.go_accept = accept && rows.go;
  assign status.acc_done = done;
  assign status.out_free = !out_valid || product.ready;

endmodule

### src/mm4_controller.sv
// Sequencer that steps rows and inner-product terms through the datapath and loads results.
module mm4_controller (
  input  logic clk,
  input  logic rst,
  input  mm4_pkg::status_t status,
  output mm4_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    LOAD
  } state_t;

  state_t state;
  state_t state_next;
  mm4_pkg::idx_t r;
  mm4_pkg::idx_t r_next;
  mm4_pkg::idx_t k;
  mm4_pkg::idx_t k_next;

  always_comb begin
    state_next = state;
    r_next = r;
    k_next = k;
    unique case (state)
      IDLE: begin
        if (status.go_accept) begin
          state_next = RUN;
          r_next = '0;
          k_next = '0;
        end
      end
      RUN: begin
        k_next = k + 1'b1;
        if (k == mm4_pkg::LAST_IDX) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        if (status.acc_done) begin
          state_next = LOAD;
        end
      end
      LOAD: begin
        if (status.out_free) begin
          if (r == mm4_pkg::LAST_IDX) begin
            state_next = IDLE;
          end else begin
            state_next = RUN;
            r_next = r + 1'b1;
            k_next = '0;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      r <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      r <= r_next;
      k <= k_next;
    end
  end

  assign cmd.in_ready = (state == IDLE);
  assign cmd.rd_en = (state == RUN);
  assign cmd.row = r;
  assign cmd.kk = k;
  assign cmd.load = (state == LOAD) && status.out_free;
  assign cmd.out_last = (r == mm4_pkg::LAST_IDX);

endmodule
